@@ hdl/lrn_pkg.sv @@
// Shared types, register codes and the root table for the LRN block.
`timescale 1ns / 1ps
package lrn_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SQUARE_W    = 32;
  localparam int SUM_W       = 36;
  localparam int HALF_W      = 3;
  localparam int SCALE_W     = 24;
  localparam int BETA_W      = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int LOG_FRAC    = 24;
  localparam int ROOT_W      = 30;

  // Configuration register indexes.
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_HALF_WINDOW   = 2'd0;
  localparam cfg_index_t REG_SCALE         = 2'd1;
  localparam cfg_index_t REG_BETA_EXPONENT = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_channel;
  } lrn_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] normalized;
    logic                       last_of_pixel;
  } lrn_out_t;

  // One ring entry: a sample and its square.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SQUARE_W-1:0]        square;
  } ring_entry_t;

  typedef logic [LOG_FRAC-1:0][ROOT_W-1:0] root_tab_t;

  // Floor square root, one result bit per step.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] b;
    r   = '0;
    rem = v;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Successive roots 2^(-2^-(k+1)) in Q30, each the square root of the one before.
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] s;
    s    = floor_sqrt(64'd1 << 59);
    t[0] = s[ROOT_W-1:0];
    for (int k = 1; k < LOG_FRAC; k++) begin
      s    = floor_sqrt(64'(t[k-1]) << 30);
      t[k] = s[ROOT_W-1:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

@@ hdl/lrn_ring.sv @@
// Ring store of recent samples and their squares, one write and one read port.
`timescale 1ns / 1ps
module lrn_ring #(
  parameter int DEPTH = 15,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  lrn_pkg::ring_entry_t  wr_data,
  input  logic [AW-1:0]         rd_addr,
  output lrn_pkg::ring_entry_t  rd_data
);
  import lrn_pkg::*;

  ring_entry_t mem [DEPTH];
  ring_entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/lrn_norm.sv @@
// Power unit: y = x * (1 + scale*sum)^(-beta) on one shared multiplier.
`timescale 1ns / 1ps
module lrn_norm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [lrn_pkg::SAMPLE_W-1:0] x_in,
  input  logic [lrn_pkg::SUM_W-1:0]          sum_in,
  input  logic [lrn_pkg::SCALE_W-1:0]        scale_in,
  input  logic [lrn_pkg::BETA_W-1:0]         beta_in,
  output logic                               busy,
  output logic                               done,
  output logic signed [lrn_pkg::SAMPLE_W-1:0] y
);
  import lrn_pkg::*;

  typedef enum logic [3:0] {
    N_IDLE, N_MUL0, N_MUL1, N_NORM, N_LOG, N_EXPO, N_EXP, N_MAG, N_OUT
  } nstate_t;

  localparam logic [4:0] LAST_STEP = 5'(LOG_FRAC - 1);

  nstate_t                     state_r;
  logic signed [SAMPLE_W-1:0]  x_r;
  logic [SUM_W-1:0]            sum_r;
  logic [SCALE_W-1:0]          scale_r;
  logic [BETA_W-1:0]           beta_r;
  logic [41:0]                 acc_r;
  logic [50:0]                 m_r;
  logic [4:0]                  p_r;
  logic [LOG_FRAC-1:0]         frac_r;
  logic [4:0]                  i_r;
  logic [7:0]                  n_r;
  logic [LOG_FRAC-1:0]         f_r;
  logic [30:0]                 g_r;
  logic [46:0]                 prod_r;
  logic signed [SAMPLE_W-1:0]  y_r;
  logic                        done_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [60:0] base;
  logic [31:0] sq_t;
  logic [45:0] e_full;
  logic [31:0] e_val;
  logic [60:0] g_rnd;
  logic [SAMPLE_W-1:0] mag;
  logic [50:0] rnd;
  logic [50:0] r_full;
  logic [5:0]  sh;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      N_MUL0: begin
        mul_a = 32'(scale_r);
        mul_b = 32'(sum_r[17:0]);
      end
      N_MUL1: begin
        mul_a = 32'(scale_r);
        mul_b = 32'(sum_r[35:18]);
      end
      N_LOG: begin
        mul_a = m_r[31:0];
        mul_b = m_r[31:0];
      end
      N_EXPO: begin
        mul_a = 32'({p_r, frac_r});
        mul_b = 32'(beta_r);
      end
      N_EXP: begin
        mul_a = 32'(g_r);
        mul_b = 32'(ROOT_TAB[i_r]);
      end
      N_MAG: begin
        mul_a = 32'(mag);
        mul_b = 32'(g_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Per-step arithmetic around the multiplier.
  always_comb begin
    base   = 61'(acc_r) + (61'(mul_p[41:0]) << 18) + (61'd1 << 40);
    sq_t   = mul_p[61:30];
    e_full = 46'(mul_p[44:0]) + 46'd8192;
    e_val  = e_full[45:14];
    g_rnd  = mul_p[60:0] + (61'd1 << 29);
    mag    = x_r[SAMPLE_W-1] ? SAMPLE_W'(-x_r) : SAMPLE_W'(x_r);
    sh     = 6'(n_r[4:0]) + 6'd29;
    rnd    = 51'(prod_r) + (51'd1 << sh);
    r_full = rnd >> (sh + 6'd1);
  end

  // Sequencer: scale product, leading-one search, log2, power, exp2, output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            x_r     <= x_in;
            sum_r   <= sum_in;
            scale_r <= scale_in;
            beta_r  <= beta_in;
            state_r <= N_MUL0;
          end
        end
        N_MUL0: begin
          acc_r   <= mul_p[41:0];
          state_r <= N_MUL1;
        end
        N_MUL1: begin
          m_r     <= base[60:10];
          p_r     <= '0;
          state_r <= N_NORM;
        end
        N_NORM: begin
          // Shift one bit a cycle until the mantissa sits in Q1.30.
          if (m_r[50:31] != '0) begin
            m_r <= m_r >> 1;
            p_r <= p_r + 5'd1;
          end else begin
            frac_r  <= '0;
            i_r     <= '0;
            state_r <= N_LOG;
          end
        end
        N_LOG: begin
          // One fraction bit of log2 per squaring.
          m_r    <= sq_t[31] ? 51'(sq_t[31:1]) : 51'(sq_t);
          frac_r <= {frac_r[LOG_FRAC-2:0], sq_t[31]};
          i_r    <= i_r + 5'd1;
          if (i_r == LAST_STEP) begin
            state_r <= N_EXPO;
          end
        end
        N_EXPO: begin
          n_r     <= e_val[31:24];
          f_r     <= e_val[23:0];
          g_r     <= 31'd1 << 30;
          i_r     <= '0;
          state_r <= N_EXP;
        end
        N_EXP: begin
          // Multiply in one root for each set fraction bit, top bit first.
          if (f_r[LOG_FRAC-1]) begin
            g_r <= g_rnd[60:30];
          end
          f_r <= f_r << 1;
          i_r <= i_r + 5'd1;
          if (i_r == LAST_STEP) begin
            state_r <= N_MAG;
          end
        end
        N_MAG: begin
          prod_r  <= mul_p[46:0];
          state_r <= N_OUT;
        end
        N_OUT: begin
          if (n_r > 8'd20) begin
            y_r <= '0;
          end else if (x_r[SAMPLE_W-1]) begin
            y_r <= SAMPLE_W'(-r_full[SAMPLE_W-1:0]);
          end else begin
            y_r <= r_full[SAMPLE_W-1:0];
          end
          done_r  <= 1'b1;
          state_r <= N_IDLE;
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign busy = (state_r != N_IDLE);
  assign done = done_r;
  assign y    = y_r;

  // The result pulse only comes out of a finished pass.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == N_IDLE) else $error("done outside idle");

  // A start while busy would be lost.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == N_IDLE) else $error("start while busy");

  // The mantissa is below 2^32 once the log steps begin.
  a_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == N_LOG |-> m_r[50:32] == '0) else $error("mantissa out of range");

endmodule

@@ hdl/local_response_norm_across_channels.sv @@
// Top level: channel window sequencer, sample ring and power unit.
//
// Local response normalization across channels for a stream of pixels.
// Input beats on in_valid/in_stall carry one signed Q8.8 channel value and a
// last_channel flag; channels of a pixel arrive in order. Result beats on
// out_valid/out_stall carry the normalized value and last_of_pixel.
// Results lag the input by half_window channels; the beat marked
// last_channel also flushes the owed channels with shrinking windows.
// Each input beat takes window bookkeeping (write, window update, pointer
// advance) plus, for each result it causes, a ring read, an output load and
// one pass of the shared power unit, made of the 24 log2 squarings, the 24
// exp2 root products and the leading-one search, all on one multiplier. A
// last beat with half_window h costs up to h + 1 such passes. in_stall is high
// while a beat is in work.
// The output register holds a finished beat while out_stall is high; the
// block waits for it only when the next result is ready.
// Reset (synchronous, rst_n low) clears the window, the channel count and
// the ring pointer and loads half_window 2, scale 336, beta 0.75.
// Writing half_window drops the pixel in progress.
`timescale 1ns / 1ps
module local_response_norm_across_channels #(
  parameter int MAX_HALF_WINDOW = 7,
  parameter int MAX_CHANNELS    = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lrn_pkg::lrn_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lrn_pkg::lrn_out_t                 out_data,
  input  logic                              cfg_write_en,
  input  logic [lrn_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lrn_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lrn_pkg::*;

  localparam int DEPTH       = 2 * MAX_HALF_WINDOW + 1;
  localparam int PW          = $clog2(DEPTH + 1);
  localparam int COUNT_LIMIT = MAX_CHANNELS + 2 * MAX_HALF_WINDOW;
  localparam int CW          = $clog2(COUNT_LIMIT + 1);
  localparam int CMPW        = CW + 5;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_OUT_RD, S_OUT_WAIT, S_NORM, S_EMIT,
    S_POST, S_SUB_RD, S_SUB, S_ADV, S_LOOP
  } state_t;

  state_t                    state_r;
  logic [HALF_W-1:0]         half_window_r;
  logic [SCALE_W-1:0]        scale_r;
  logic [BETA_W-1:0]         beta_r;
  logic [SUM_W-1:0]          sum_r;
  logic [CW-1:0]             count_r;
  logic [PW-1:0]             ptr_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                      last_r;
  logic                      flush_r;
  logic [CMPW-1:0]           b_r;
  logic [PW-1:0]             idx_r;
  logic [PW-1:0]             oidx_r;
  logic                      flag_r;
  logic                      out_valid_r;
  lrn_out_t                  out_data_r;

  logic            ring_we;
  ring_entry_t     ring_wdata;
  ring_entry_t     ring_rdata;
  logic            norm_start;
  logic            norm_busy;
  logic            norm_done;
  logic signed [SAMPLE_W-1:0] norm_y;

  logic [CMPW-1:0] h_raw;
  logic [CMPW-1:0] h;
  logic [CMPW-1:0] c_ext;
  logic [CMPW-1:0] bc;
  logic [SQUARE_W-1:0] x_sq;
  logic            out_free;
  logic            out_load;

  // Ring index a given number of channels back from the write pointer.
  function automatic logic [PW-1:0] back_idx(logic [PW-1:0] ptr, logic [CMPW-1:0] back);
    logic [PW:0] s;
    s = (PW+1)'(ptr) + (PW+1)'(DEPTH) - (PW+1)'(back);
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  // Window bounds, the square of the new sample and the output-free test.
  always_comb begin
    h_raw    = CMPW'(half_window_r);
    h        = (h_raw > CMPW'(MAX_HALF_WINDOW)) ? CMPW'(MAX_HALF_WINDOW) : h_raw;
    c_ext    = CMPW'(count_r);
    bc       = b_r - CMPW'(1);
    x_sq     = SQUARE_W'(32'(x_r) * 32'(x_r));
    out_free = !out_valid_r || !out_stall;
    out_load = (state_r == S_EMIT) && out_free;
  end

  assign ring_we          = (state_r == S_WRITE);
  assign ring_wdata.sample = x_r;
  assign ring_wdata.square = x_sq;
  assign norm_start       = (state_r == S_OUT_WAIT);

  lrn_ring #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ptr_r),
    .wr_data (ring_wdata),
    .rd_addr (idx_r),
    .rd_data (ring_rdata)
  );

  lrn_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (norm_start),
    .x_in     (ring_rdata.sample),
    .sum_in   (sum_r),
    .scale_in (scale_r),
    .beta_in  (beta_r),
    .busy     (norm_busy),
    .done     (norm_done),
    .y        (norm_y)
  );

  // Channel sequencer, window state, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      half_window_r <= 3'd2;
      scale_r       <= 24'd336;
      beta_r        <= 16'd12288;
      sum_r         <= '0;
      count_r       <= '0;
      ptr_r         <= '0;
      flush_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= in_data.sample;
            last_r  <= in_data.last_channel;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          sum_r <= sum_r + SUM_W'(x_sq);
          if (c_ext >= h) begin
            idx_r   <= back_idx(ptr_r, h);
            flag_r  <= last_r && (h == '0);
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_POST;
          end
        end
        S_OUT_RD: state_r <= S_OUT_WAIT;
        S_OUT_WAIT: state_r <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r              <= 1'b1;
            out_data_r.normalized    <= norm_y;
            out_data_r.last_of_pixel <= flag_r;
            state_r                  <= flush_r ? S_LOOP : S_POST;
          end
        end
        S_POST: begin
          if (last_r) begin
            flush_r <= 1'b1;
            b_r     <= h;
            state_r <= S_LOOP;
          end else if (c_ext >= (h << 1)) begin
            idx_r   <= back_idx(ptr_r, h << 1);
            state_r <= S_SUB_RD;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_SUB_RD: state_r <= S_SUB;
        S_SUB: begin
          sum_r <= sum_r - SUM_W'(ring_rdata.square);
          if (flush_r) begin
            idx_r   <= oidx_r;
            state_r <= S_OUT_RD;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          ptr_r   <= (ptr_r == PW'(DEPTH - 1)) ? '0 : ptr_r + PW'(1);
          count_r <= (count_r == CW'(COUNT_LIMIT)) ? count_r : count_r + CW'(1);
          state_r <= S_IDLE;
        end
        S_LOOP: begin
          // Flush the owed channels, nearest the window end last.
          if (b_r == '0) begin
            sum_r   <= '0;
            count_r <= '0;
            ptr_r   <= '0;
            flush_r <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            b_r <= bc;
            if (bc > c_ext) begin
              state_r <= S_LOOP;
            end else if (bc + h + CMPW'(1) <= c_ext) begin
              idx_r   <= back_idx(ptr_r, bc + h + CMPW'(1));
              oidx_r  <= back_idx(ptr_r, bc);
              flag_r  <= (bc == '0);
              state_r <= S_SUB_RD;
            end else begin
              idx_r   <= back_idx(ptr_r, bc);
              flag_r  <= (bc == '0);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Register writes must arrive only while the block is idle; the block does not enforce it.
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_HALF_WINDOW: begin
            half_window_r <= cfg_data[HALF_W-1:0];
            sum_r         <= '0;
            count_r       <= '0;
            ptr_r         <= '0;
          end
          REG_SCALE:         scale_r <= cfg_data[SCALE_W-1:0];
          REG_BETA_EXPONENT: beta_r  <= cfg_data[BETA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The ring pointer stays inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PW'(DEPTH - 1)) else $error("ring pointer out of range");

  // The power unit is only started when it is free.
  a_norm_free: assert property (@(posedge clk) disable iff (!rst_n)
    norm_start |-> !norm_busy) else $error("power unit started while busy");

  // A result beat is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall)) else $error("output overrun");

  // Ending a flush leaves an empty window.
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP && b_r == '0 && !cfg_write_en) |=>
      (count_r == '0 && sum_r == '0)) else $error("pixel not cleared");

endmodule

@@ bench/lrn_norm_checker.sv @@
// Checker for the LRN block: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps
module lrn_norm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  lrn_pkg::lrn_in_t                in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  lrn_pkg::lrn_out_t               out_data,
  input  logic                            cfg_write_en,
  input  logic [lrn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lrn_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatch_count,
  output int                              owed_count
);
  import lrn_pkg::*;

  localparam int RING_LEN   = 15;
  localparam int CHAN_LIMIT = 1024 + 2 * 7;

  // Shadow copy of the registers and of the window state.
  logic [HALF_W-1:0]        half_win;
  logic [SCALE_W-1:0]       scale_q24;
  logic [BETA_W-1:0]        beta_q14;
  logic signed [15:0]       sample_hist [RING_LEN];
  logic [31:0]              square_hist [RING_LEN];
  logic [63:0]              sq_window;
  int unsigned              chan_seen;
  int unsigned              hist_ptr;
  lrn_out_t                 norm_expected [$];

  // y = x * (1 + scale*S)^(-beta) in fixed point: log2, times beta, exp2.
  function automatic logic [15:0] power_norm(logic signed [15:0] x, logic [63:0] s);
    logic [63:0] base, m, frac, lg, e, f, g, mag, prod, r;
    int p, n, xi;
    base = 64'(scale_q24) * s + (64'd1 << 40);
    p = 40;
    while (p < 62 && (base >> (p + 1)) != 0) p++;
    m = base >> (p - 30);
    frac = 0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    lg = (64'(p - 40) << LOG_FRAC) | frac;
    e = (lg * 64'(beta_q14) + (64'd1 << 13)) >> 14;
    n = int'(e >> LOG_FRAC);
    f = e & 64'hFF_FFFF;
    g = 64'd1 << 30;
    for (int i = 0; i < LOG_FRAC; i++) begin
      if (f[LOG_FRAC-1-i]) g = (g * 64'(ROOT_TAB[i]) + (64'd1 << 29)) >> 30;
    end
    xi = x;
    mag = (xi < 0) ? 64'(-xi) : 64'(xi);
    prod = mag * g;
    if (n > 20) r = 0;
    else r = (prod + (64'd1 << (29 + n))) >> (30 + n);
    return (xi < 0) ? 16'(-r) : 16'(r);
  endfunction

  function automatic int unsigned back_slot(int unsigned b);
    return (hist_ptr + RING_LEN - b) % RING_LEN;
  endfunction

  function automatic void clear_window();
    sq_window = 0;
    chan_seen = 0;
    hist_ptr  = 0;
  endfunction

  // Take one input beat and queue every result it owes.
  function automatic void absorb_channel(lrn_in_t d);
    int unsigned h, c;
    int xi;
    lrn_out_t res;
    h  = half_win;
    c  = chan_seen;
    xi = d.sample;
    sample_hist[hist_ptr] = d.sample;
    square_hist[hist_ptr] = 32'(xi * xi);
    sq_window += 64'(square_hist[hist_ptr]);
    if (c >= h) begin
      res.normalized    = power_norm(sample_hist[back_slot(h)], sq_window);
      res.last_of_pixel = d.last_channel && h == 0;
      norm_expected.push_back(res);
    end
    if (!d.last_channel) begin
      if (c >= 2 * h) sq_window -= 64'(square_hist[back_slot(2 * h)]);
      sq_window &= (64'd1 << SUM_W) - 1;
      hist_ptr  = (hist_ptr + 1) % RING_LEN;
      chan_seen = (c + 1 > CHAN_LIMIT) ? CHAN_LIMIT : c + 1;
    end else begin
      // Flush the owed channels with windows that shrink at the end.
      for (int b = int'(h) - 1; b >= 0; b--) begin
        if (b > c) continue;
        if (b + h + 1 <= c) sq_window -= 64'(square_hist[back_slot(b + h + 1)]);
        res.normalized    = power_norm(sample_hist[back_slot(b)], sq_window);
        res.last_of_pixel = (b == 0);
        norm_expected.push_back(res);
      end
      clear_window();
    end
  endfunction

  // All sampling happens at the edge, before the block updates its outputs.
  always @(posedge clk) begin
    lrn_out_t want;
    if (!rst_n) begin
      half_win  = 3'd2;
      scale_q24 = 24'd336;
      beta_q14  = 16'd12288;
      clear_window();
      norm_expected.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_HALF_WINDOW: begin
            half_win = cfg_data[HALF_W-1:0];
            clear_window();
          end
          REG_SCALE:         scale_q24 = cfg_data[SCALE_W-1:0];
          REG_BETA_EXPONENT: beta_q14 = cfg_data[BETA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_channel(in_data);
      if (out_valid && !out_stall) begin
        if (norm_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: normalized %0d last %0b",
                     out_data.normalized, out_data.last_of_pixel);
        end else begin
          want = norm_expected.pop_front();
          if (want.normalized !== out_data.normalized ||
              want.last_of_pixel !== out_data.last_of_pixel) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: normalized %0d/%0d last %0b/%0b (expected/actual)",
                       want.normalized, out_data.normalized,
                       want.last_of_pixel, out_data.last_of_pixel);
          end
        end
      end
    end
    owed_count = norm_expected.size();
  end

endmodule

@@ bench/local_response_norm_across_channels_tb.sv @@
// Testbench top for the LRN block: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module local_response_norm_across_channels_tb;
  import lrn_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  lrn_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  lrn_out_t               out_data;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatch_count;
  int                     owed_count;
  int                     send_idle_pct;
  int                     recv_idle_pct;

  local_response_norm_across_channels i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_write_en, .cfg_index, .cfg_data
  );

  lrn_norm_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_write_en, .cfg_index, .cfg_data, .mismatch_count, .owed_count
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hard limit on the run.
  initial begin
    #(12 * 3_000_000);
    $display("[local_response_norm_across_channels] ERROR");
    $finish;
  end

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  // Wait until every owed result is out, plus the block's longest pass.
  task automatic drain();
    drop_valid();
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // One input beat, held until the block takes it.
  task automatic send_beat(logic signed [15:0] s, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_data.sample       <= s;
    in_data.last_channel <= last;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($signed(12'($urandom)));
      2:       return 16'($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed(9'($urandom)));
    endcase
  endfunction

  task automatic send_pixel(int len);
    for (int k = 0; k < len; k++) begin
      send_beat(rand_sample(), k == len - 1);
    end
  endtask

  initial begin
    int plen;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_write_en  = 1'b0;
    cfg_index     = REG_HALF_WINDOW;
    cfg_data      = '0;
    send_idle_pct = 20;
    recv_idle_pct = 58;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, extremes, a single-channel pixel.
    send_beat(16'sh7FFF, 1'b0);
    send_beat(-16'sh8000, 1'b0);
    send_beat(16'sd0, 1'b0);
    send_beat(16'sd1, 1'b0);
    send_beat(-16'sd1, 1'b1);
    send_beat(16'sh1234, 1'b1);
    // Half window rewritten mid-pixel drops the pixel in progress.
    send_beat(16'sh0100, 1'b0);
    write_reg(REG_HALF_WINDOW, 24'd3);
    send_beat(16'sh0200, 1'b0);
    send_beat(-16'sh0300, 1'b1);
    // Largest scale and beta push the exponent past the shift limit.
    write_reg(REG_SCALE, 24'hFF_FFFF);
    write_reg(REG_BETA_EXPONENT, 24'hFFFF);
    write_reg(REG_HALF_WINDOW, 24'd7);
    send_beat(-16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b0);
    send_beat(-16'sh8000, 1'b0);
    send_beat(16'sh0001, 1'b1);
    // Beta zero passes samples through.
    write_reg(REG_BETA_EXPONENT, 24'd0);
    write_reg(REG_HALF_WINDOW, 24'd0);
    send_beat(-16'sh8000, 1'b0);
    send_beat(16'sh7FFF, 1'b1);

    // Random phases with changing settings and idling.
    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 20 : (ph < 6) ? 58 : 0;
      recv_idle_pct = (ph < 3) ? 58 : (ph < 6) ? 20 : 0;
      write_reg(REG_HALF_WINDOW, (ph % 3 == 0) ? 24'd0 : (ph % 3 == 1) ? 24'd7
                                 : 24'($urandom_range(0, 7)));
      write_reg(REG_SCALE, (ph == 4) ? 24'hFF_FFFF : (ph == 2) ? 24'd0
                           : 24'($urandom_range(0, 3000)));
      write_reg(REG_BETA_EXPONENT, (ph == 5) ? 24'hFFFF : (ph == 1) ? 24'd0
                                   : 24'($urandom_range(0, 65535)));
      for (int items = 0; items < 24; items += plen) begin
        plen = ($urandom_range(9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
        send_pixel(plen);
        if ($urandom_range(7) == 0) drain();
      end
      // Scale and beta changed partway through a pixel.
      send_beat(rand_sample(), 1'b0);
      send_beat(rand_sample(), 1'b0);
      write_reg(REG_SCALE, 24'($urandom_range(0, 5000)));
      write_reg(REG_BETA_EXPONENT, 24'($urandom));
      send_pixel(3);
    end

    drain();
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("[local_response_norm_across_channels] OK");
    end else begin
      $display("[local_response_norm_across_channels] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lrn_pkg.sv
hdl/lrn_ring.sv
hdl/lrn_norm.sv
hdl/local_response_norm_across_channels.sv
bench/lrn_norm_checker.sv
bench/local_response_norm_across_channels_tb.sv
